// ----- rtl/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 4;
    localparam int WORD_BYTES = CFG_DATA_W / BYTE_W;

    typedef logic [CFG_DATA_W-1:0] word_t;
    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [LEN_W-1:0]      len_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LEN   = 2'd0,
        REG_PATTERN_BYTES = 2'd1,
        REG_REPLACE_LEN   = 2'd2,
        REG_REPLACE_BYTES = 2'd3
    } cfg_reg_t;

    // One output slot: a byte and its end-of-run mark.
    typedef struct packed {
        logic  last;
        byte_t data;
    } slot_t;

endpackage

// ----- rtl/sfr_suffix_cell.sv -----
// Suffix cell: tests whether the last K examined bytes form a pattern prefix.
module sfr_suffix_cell #(
    parameter int K = 1
) (
    input  sfr_pkg::word_t pattern,
    input  sfr_pkg::len_t  held,
    input  sfr_pkg::byte_t in_byte,
    input  sfr_pkg::len_t  best_in,
    output sfr_pkg::len_t  best_out
);
    import sfr_pkg::*;

    logic ok;

    always_comb begin
        logic [2:0] s;
        logic [2:0] idx;
        ok  = (len_t'(K) <= held) && (in_byte == pattern[BYTE_W*(K-1) +: BYTE_W]);
        s   = 3'(held + len_t'(1) - len_t'(K));
        idx = s;
        for (int j = 0; j < K - 1; j++) begin
            idx = s + 3'(j);
            if (pattern[{idx, 3'b000} +: BYTE_W] != pattern[BYTE_W*j +: BYTE_W]) begin
                ok = 1'b0;
            end
        end
    end

    // Longer suffix wins: higher cells feed down the chain.
    assign best_out = (best_in != '0) ? best_in : (ok ? len_t'(K) : '0);

endmodule

// ----- rtl/sfr_slot.sv -----
// Output slot cell: loads a run byte or takes its neighbor's byte on a shift.
module sfr_slot (
    input  logic           aclk,
    input  logic           shift,
    input  logic           load,
    input  sfr_pkg::slot_t ld,
    input  sfr_pkg::slot_t nb,
    output sfr_pkg::slot_t q
);
    import sfr_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb begin
        slot_next = slot_reg;
        if (load) begin
            slot_next = ld;
        end else if (shift) begin
            slot_next = nb;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign q = slot_reg;

endmodule

// ----- rtl/stream_find_replace_top.sv -----
// Top level of the streaming find-and-replace block.
// Each accepted byte is checked combinationally against the held partial
// match by a chain of suffix cells, and the bytes it releases (0 to 8) are
// loaded into a row of output slots that shift one byte per cycle toward
// m_tdata while m_tready is high. An input request is taken whenever at most
// one result byte is still queued, so a byte that releases more than one
// result stalls the input until the output slot row has drained to at most
// one queued byte. end_of_stream (s_tlast) flushes the held partial match;
// m_tlast marks the final result of each input request. There is no clearing
// pass after reset.
module stream_find_replace_top #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic                       s_tlast,   // end_of_stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sfr_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,   // last_of_run
    input  logic                       cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfr_pkg::*;

    localparam int RUN_MAX = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
    localparam int DEPTH   = RUN_MAX + 1;
    localparam int CW      = $clog2(DEPTH + 1);

    // configuration
    len_t  pat_len_reg;
    word_t pat_bytes_reg;
    len_t  rep_len_reg;
    word_t rep_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   <= len_t'(1);
            pat_bytes_reg <= '0;
            rep_len_reg   <= '0;
            rep_bytes_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LEN:   pat_len_reg   <= cfg_data[LEN_W-1:0];
                REG_PATTERN_BYTES: pat_bytes_reg <= cfg_data;
                REG_REPLACE_LEN:   rep_len_reg   <= cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES: rep_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    len_t plen;
    len_t rlen;
    len_t held;
    len_t mc_reg;
    len_t mc_next;

    always_comb begin
        plen = pat_len_reg;
        if (plen == '0) begin
            plen = len_t'(1);
        end
        if (plen > len_t'(MAX_PATTERN)) begin
            plen = len_t'(MAX_PATTERN);
        end
        rlen = (rep_len_reg > len_t'(MAX_REPLACE)) ? len_t'(MAX_REPLACE) : rep_len_reg;
        held = (mc_reg >= plen) ? plen - len_t'(1) : mc_reg;
    end

    // suffix search
    len_t best_chain [MAX_PATTERN+1];
    assign best_chain[MAX_PATTERN] = '0;

    for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_suffix
        sfr_suffix_cell #(.K(k)) u_cell (
            .pattern  (pat_bytes_reg),
            .held     (held),
            .in_byte  (s_tdata),
            .best_in  (best_chain[k]),
            .best_out (best_chain[k-1])
        );
    end

    // run of released bytes
    byte_t cur_byte;
    logic  hit;
    logic  full;
    byte_t run_byte [RUN_MAX];
    len_t  run_len;

    assign cur_byte = pat_bytes_reg[{held[2:0], 3'b000} +: BYTE_W];
    assign hit      = (s_tdata == cur_byte);
    assign full     = hit && (held + len_t'(1) == plen);

    always_comb begin
        mc_next = mc_reg;
        run_len = '0;
        for (int i = 0; i < RUN_MAX; i++) begin
            run_byte[i] = pat_bytes_reg[BYTE_W*i +: BYTE_W];
        end
        if (s_tlast) begin
            run_len = held;
            mc_next = '0;
        end else if (full) begin
            for (int i = 0; i < RUN_MAX; i++) begin
                run_byte[i] = rep_bytes_reg[BYTE_W*i +: BYTE_W];
            end
            run_len = rlen;
            mc_next = '0;
        end else if (hit) begin
            mc_next = held + len_t'(1);
        end else begin
            for (int i = 0; i < RUN_MAX; i++) begin
                if (len_t'(i) == held) begin
                    run_byte[i] = s_tdata;
                end
            end
            run_len = held + len_t'(1) - best_chain[0];
            mc_next = best_chain[0];
        end
    end

    // output slot row
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          shift;
    logic          accept;
    logic          base_one;
    logic [CW-1:0] base;
    slot_t         slot_q  [DEPTH];
    slot_t         slot_ld [DEPTH];
    logic          slot_load [DEPTH];

    assign m_tvalid = (count_reg != '0);
    assign s_tready = (count_reg <= CW'(1));
    assign shift    = m_tvalid && m_tready;
    assign accept   = s_tvalid && s_tready;
    assign base_one = (count_reg == CW'(1)) && !shift;
    assign base     = base_one ? CW'(1) : '0;
    assign m_tdata  = slot_q[0].data;
    assign m_tlast  = slot_q[0].last;

    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        byte_t ld_a;
        byte_t ld_b;
        slot_t nb;

        if (i < RUN_MAX) begin : g_a
            assign ld_a = run_byte[i];
        end else begin : g_a0
            assign ld_a = '0;
        end
        if (i >= 1) begin : g_b
            assign ld_b = run_byte[i-1];
        end else begin : g_b0
            assign ld_b = '0;
        end
        if (i < DEPTH - 1) begin : g_nb
            assign nb = slot_q[i+1];
        end else begin : g_nb0
            assign nb = '0;
        end

        assign slot_ld[i].data = base_one ? ld_b : ld_a;
        assign slot_ld[i].last = (CW'(i) == base + CW'(run_len) - CW'(1));
        assign slot_load[i]    = accept && (CW'(i) >= base)
                                 && (CW'(i) - base < CW'(run_len));

        sfr_slot u_slot (
            .aclk  (aclk),
            .shift (shift),
            .load  (slot_load[i]),
            .ld    (slot_ld[i]),
            .nb    (nb),
            .q     (slot_q[i])
        );
    end

    always_comb begin
        count_next = count_reg - CW'(shift);
        if (accept) begin
            count_next = count_next + CW'(run_len);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            mc_reg    <= '0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                mc_reg <= mc_next;
            end
        end
    end

endmodule

// ----- rtl/sfr_checker.sv -----
// Port-level checker for the find-and-replace top level, with its bind.
module sfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input only stalls while results are queued
    a_stall_has_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/stream_find_replace_top_tb.sv -----
// Self-checking testbench for stream_find_replace_top: directed table, then random phases.
`timescale 1ns / 1ps

module stream_find_replace_top_tb;
    import sfr_pkg::*;

    localparam int RANDOM_REQUESTS = 420;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DIRECTED_ROWS   = 32;

    typedef enum logic [0:0] {DO_WRITE, DO_SEND} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        cfg_reg_t   reg_idx;
        word_t      value;
        byte_t      data;
        logic       eos;
        logic       typed;
        logic [3:0] n_exp;
        word_t      exp_word;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block's registers and held match length
    len_t  pat_len;
    word_t pat_word;
    len_t  rep_len;
    word_t rep_word;
    int    held_len;

    slot_t edited_q [$];

    int  mismatches      = 0;
    int  requests_sent   = 0;
    int  random_sent     = 0;
    int  settings_used   = 0;
    int  flushes         = 0;
    int  results_checked = 0;
    int  longest_run     = 0;
    int  burst_left      = 0;
    int  cycle_count     = 0;
    bit  hold_req        = 1'b0;
    bit  hold_done       = 1'b0;

    row_t directed_plan [DIRECTED_ROWS] = '{
        // reset settings: pattern 00 of length 1, empty replacement
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd1, 64'hFF},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h00, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hA5, 1'b1, 1'b1, 4'd0, 64'h0},
        // zero pattern length acts as 1, replace length saturates at 8
        '{DO_WRITE, REG_PATTERN_LEN,   64'h0, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_REPLACE_LEN,   64'hF, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_REPLACE_BYTES, 64'h0102030405060708, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h00, 1'b0, 1'b1, 4'd8, 64'h0102030405060708},
        // "aab" -> "XY", with the rescan case "aaab"
        '{DO_WRITE, REG_PATTERN_LEN,   64'h3, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_PATTERN_BYTES, 64'h626161, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_REPLACE_LEN,   64'h2, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_REPLACE_BYTES, 64'h5958, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h62, 1'b0, 1'b0, 4'd0, 64'h0},
        // flush of a held partial match
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h00, 1'b1, 1'b0, 4'd0, 64'h0},
        // pattern shortened while two bytes are held
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_PATTERN_LEN,   64'h2, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h62, 1'b0, 1'b0, 4'd0, 64'h0},
        // pattern length 15 saturates to 8; seven held bytes released by a miss
        '{DO_WRITE, REG_PATTERN_LEN,   64'hF, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_PATTERN_BYTES, 64'hFFFFFFFFFFFFFFFF, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_WRITE, REG_REPLACE_LEN,   64'h0, 8'h00, 1'b0, 1'b0, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{DO_SEND,  REG_PATTERN_LEN,   64'h0, 8'h00, 1'b0, 1'b1, 4'd8, 64'h00FFFFFFFFFFFFFF}
    };

    stream_find_replace_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] in_byte
        .s_tlast   (s_tlast),   // end_of_stream
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] out_byte
        .m_tlast   (m_tlast),   // last_of_run
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, edited_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Edits one request against the held prefix; returns the number of released bytes.
    function automatic int find_replace_step(input byte_t b, input bit eos,
                                             output slot_t run [WORD_BYTES]);
        int    plen, rlen, m, n, k, cnt, i, j;
        bit    ok;
        byte_t cand [WORD_BYTES];
        plen = (pat_len == 0) ? 1 : ((pat_len > WORD_BYTES) ? WORD_BYTES : int'(pat_len));
        m    = (held_len >= plen) ? plen - 1 : held_len;
        cnt  = 0;
        for (i = 0; i < WORD_BYTES; i++) run[i] = '0;
        if (eos) begin
            for (i = 0; i < m; i++) begin
                run[cnt] = {1'b0, pat_word[8*i +: 8]};
                cnt++;
            end
            held_len = 0;
        end else if (b == pat_word[8*m +: 8]) begin
            if (m + 1 == plen) begin
                rlen = (rep_len > WORD_BYTES) ? WORD_BYTES : int'(rep_len);
                for (i = 0; i < rlen; i++) begin
                    run[cnt] = {1'b0, rep_word[8*i +: 8]};
                    cnt++;
                end
                held_len = 0;
            end else begin
                held_len = m + 1;
            end
        end else begin
            n = m + 1;
            for (i = 0; i < m; i++) cand[i] = pat_word[8*i +: 8];
            cand[m] = b;
            // longest suffix of the examined bytes that is still a prefix
            for (k = m; k > 0; k--) begin
                ok = 1'b1;
                for (j = 0; j < k; j++)
                    if (cand[n-k+j] != pat_word[8*j +: 8]) ok = 1'b0;
                if (ok) break;
            end
            for (i = 0; i < n - k; i++) begin
                run[cnt] = {1'b0, cand[i]};
                cnt++;
            end
            held_len = k;
        end
        if (cnt > 0) run[cnt-1].last = 1'b1;
        return cnt;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input word_t value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            REG_PATTERN_LEN:   pat_len  = value[LEN_W-1:0];
            REG_PATTERN_BYTES: pat_word = value;
            REG_REPLACE_LEN:   rep_len  = value[LEN_W-1:0];
            REG_REPLACE_BYTES: rep_word = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drop the request line and wait until every released byte has come out.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (edited_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic offer_request(input byte_t b, input bit eos, input bit typed,
                                 input int typed_n, input word_t typed_word);
        slot_t run [WORD_BYTES];
        int    n, gap, i;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            for (i = 0; i < gap; i++) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        n = find_replace_step(b, eos, run);
        if (typed) begin
            for (i = 0; i < typed_n; i++)
                edited_q.push_back({(i == typed_n - 1), typed_word[8*i +: 8]});
        end else begin
            for (i = 0; i < n; i++) edited_q.push_back(run[i]);
        end
        requests_sent++;
        if (eos) flushes++;
        if (n > longest_run) longest_run = n;
    endtask

    always @(posedge aclk) begin : watch_results
        slot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (edited_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                          m_tdata, m_tlast));
            end else begin
                want = edited_q.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("result %0d byte got %02h want %02h",
                                              results_checked, m_tdata, want.data));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("result %0d last got %0b want %0b",
                                              results_checked, m_tlast, want.last));
            end
        end
    end

    // Receiver: changing stall patterns plus one long hold-off on request.
    initial begin : result_sink
        int mode, span, hold_left;
        m_tready = 1'b0;
        mode     = 0;
        span     = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 1) begin
                    @(negedge aclk);
                    hold_left--;
                end
                hold_done = 1'b1;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(4, 60);
                end
                span--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (span % 5 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int    r, i, pick, frag_len, phase_len, in_phase, plen, plen_val, rlen_val;
        byte_t alpha [2];
        word_t junk;
        row_t  row;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_PATTERN_LEN;
        cfg_data  = '0;
        pat_len   = 4'd1;
        pat_word  = '0;
        rep_len   = '0;
        rep_word  = '0;
        held_len  = 0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_plan[r];
            if (row.kind == DO_WRITE) begin
                settle();
                write_reg(row.reg_idx, row.value);
            end else begin
                offer_request(row.data, row.eos, row.typed, int'(row.n_exp), row.exp_word);
            end
        end

        while (random_sent < RANDOM_REQUESTS) begin
            settle();
            case (settings_used)
                0: begin plen_val = 8;  rlen_val = 8; end
                1: begin plen_val = 1;  rlen_val = 0; end
                2: begin plen_val = 15; rlen_val = 15; end
                default: begin
                    pick     = $urandom_range(0, 9);
                    plen_val = (pick == 0) ? 0 :
                               (pick == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
                    pick     = $urandom_range(0, 9);
                    rlen_val = (pick == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
                end
            endcase
            // a two-byte alphabet makes overlapping prefixes common
            if ($urandom_range(0, 3) == 0) begin
                junk = {$urandom, $urandom};
            end else begin
                alpha[0] = byte_t'($urandom_range(0, 255));
                alpha[1] = byte_t'($urandom_range(0, 255));
                for (i = 0; i < WORD_BYTES; i++) junk[8*i +: 8] = alpha[$urandom_range(0, 1)];
            end
            write_reg(REG_PATTERN_BYTES, junk);
            alpha[0] = junk[7:0];
            alpha[1] = junk[15:8];
            junk = {$urandom, $urandom};
            write_reg(REG_PATTERN_LEN, {junk[63:4], 4'(plen_val)});
            junk = {$urandom, $urandom};
            write_reg(REG_REPLACE_LEN, {junk[63:4], 4'(rlen_val)});
            write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
            settings_used++;

            plen = (pat_len == 0) ? 1 : ((pat_len > WORD_BYTES) ? WORD_BYTES : int'(pat_len));
            phase_len = $urandom_range(25, 50);
            in_phase  = 0;
            while (in_phase < phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    for (i = 0; i < plen; i++)
                        offer_request(pat_word[8*i +: 8], 1'b0, 1'b0, 0, '0);
                    frag_len = plen;
                end else if (pick < 60) begin
                    frag_len = $urandom_range(1, plen);
                    for (i = 0; i < frag_len; i++)
                        offer_request(pat_word[8*i +: 8], 1'b0, 1'b0, 0, '0);
                end else if (pick < 80) begin
                    frag_len = $urandom_range(1, 4);
                    for (i = 0; i < frag_len; i++)
                        offer_request(alpha[$urandom_range(0, 1)], 1'b0, 1'b0, 0, '0);
                end else begin
                    offer_request(byte_t'($urandom_range(0, 255)), (pick >= 90), 1'b0, 0, '0);
                    frag_len = 1;
                end
                in_phase    += frag_len;
                random_sent += frag_len;
                if (random_sent >= 150) hold_req = 1'b1;
            end
        end

        settle();
        repeat (16) @(posedge aclk);

        $display("Covered %0d requests (%0d random) over %0d register settings, %0d flushes.",
                 requests_sent, random_sent, settings_used, flushes);
        $display("Checked %0d result bytes; longest run %0d; long output hold-off %s.",
                 results_checked, longest_run, hold_done ? "done" : "not reached");
        if (mismatches == 0 && edited_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
